@@ design/assert_macros.svh @@
// Shared assertion macros for the grouping block checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sgbk_pkg.sv @@
package sgbk_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic idx_inc;
    logic set_ovf;
    logic rec_hit;
    logic rec_new;
    logic pfx_wr;
    logic sct_wr;
    logic item_ld;
    logic grp_ld;
    logic emit;
    logic out_ld;
    logic list_clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic gc_zero;
    logic last_q;
    logic match;
    logic end_grp;
    logic end_item;
    logic out_free;
  } sts_t;

endpackage

@@ design/sgbk_ram.sv @@
module sgbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sgbk_ctrl.sv @@
module sgbk_ctrl import sgbk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_CHECK    = 13'b0000000000010,
    S_SCAN_RD  = 13'b0000000000100,
    S_SCAN_CMP = 13'b0000000001000,
    S_PFX_RD   = 13'b0000000010000,
    S_PFX_WR   = 13'b0000000100000,
    S_SCT_TAG  = 13'b0000001000000,
    S_SCT_CUR  = 13'b0000010000000,
    S_SCT_WR   = 13'b0000100000000,
    S_EM_PERM  = 13'b0001000000000,
    S_EM_TAG   = 13'b0010000000000,
    S_EM_GRP   = 13'b0100000000000,
    S_EM_OUT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.full) begin
          // drop the beat, keep the list open unless it closes here
          cmd.set_ovf = 1'b1;
          if (sts.last_q) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_PFX_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.gc_zero) begin
          cmd.rec_new = 1'b1;
          if (sts.last_q) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_PFX_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (sts.match || sts.end_grp) begin
          cmd.rec_hit = sts.match;
          cmd.rec_new = !sts.match;
          if (sts.last_q) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_PFX_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_PFX_RD: begin
        state_next = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd.pfx_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.end_grp) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCT_TAG;
        end else begin
          state_next = S_PFX_RD;
        end
      end
      S_SCT_TAG: begin
        state_next = S_SCT_CUR;
      end
      S_SCT_CUR: begin
        cmd.grp_ld = 1'b1;
        state_next = S_SCT_WR;
      end
      S_SCT_WR: begin
        cmd.sct_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.end_item) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EM_PERM;
        end else begin
          state_next = S_SCT_TAG;
        end
      end
      S_EM_PERM: begin
        cmd.emit   = 1'b1;
        state_next = S_EM_TAG;
      end
      S_EM_TAG: begin
        cmd.emit    = 1'b1;
        cmd.item_ld = 1'b1;
        state_next  = S_EM_GRP;
      end
      S_EM_GRP: begin
        cmd.emit   = 1'b1;
        cmd.grp_ld = 1'b1;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.idx_inc = 1'b1;
          if (sts.end_item) begin
            cmd.list_clr = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_EM_PERM;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/sgbk_dp.sv @@
module sgbk_dp import sgbk_pkg::*; #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] query_key,
  input  logic               last,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [IDX_W-1:0]   item_index,
  output logic [IDX_W-1:0]   group_index,
  output logic [IDX_W-1:0]   group_start,
  output logic [CNT_W-1:0]   group_size,
  output logic [CNT_W-1:0]   group_total,
  output logic               overflow,
  output logic               last_out
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [63:0] key_ext;
  logic [KEY_BITS-1:0] key_q;
  logic                last_q;
  logic [CW-1:0]       ic;
  logic [CW-1:0]       gc;
  logic                ovf;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       acc;
  logic [AW-1:0]       grp_q;
  logic [AW-1:0]       item_q;

  logic [KEY_BITS-1:0] key_rd;
  logic [CW-1:0]       size_rd;
  logic [AW-1:0]       tag_rd;
  logic [AW-1:0]       off_rd;
  logic [AW-1:0]       cur_rd;
  logic [AW-1:0]       perm_rd;

  logic [AW-1:0]       emit_addr;
  logic [AW-1:0]       size_raddr;
  logic [AW-1:0]       tag_raddr;
  logic [AW-1:0]       size_waddr;
  logic [CW-1:0]       size_wdata;
  logic [AW-1:0]       tag_wdata;
  logic [AW-1:0]       cur_waddr;
  logic [AW-1:0]       cur_wdata;

  assign key_ext = 64'(query_key);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_q  <= key_ext[KEY_BITS-1:0];
      last_q <= last;
    end
    if (cmd.item_ld) begin
      item_q <= perm_rd;
    end
    if (cmd.grp_ld) begin
      grp_q <= tag_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic  <= '0;
      gc  <= '0;
      ovf <= 1'b0;
      idx <= '0;
      acc <= '0;
    end else begin
      if (cmd.list_clr) begin
        ic  <= '0;
        gc  <= '0;
        ovf <= 1'b0;
      end else begin
        if (cmd.rec_hit || cmd.rec_new) begin
          ic <= ic + CW'(1);
        end
        if (cmd.rec_new) begin
          gc <= gc + CW'(1);
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.idx_clr) begin
        idx <= '0;
        acc <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + CW'(1);
        end
        if (cmd.pfx_wr) begin
          acc <= acc + size_rd;
        end
      end
    end
  end

  // Emission reads offset and size at the group of the current slot.
  assign emit_addr  = cmd.grp_ld ? tag_rd : grp_q;
  assign size_raddr = cmd.emit ? emit_addr : idx[AW-1:0];
  assign tag_raddr  = cmd.emit ? perm_rd : idx[AW-1:0];
  assign size_waddr = cmd.rec_hit ? idx[AW-1:0] : gc[AW-1:0];
  assign size_wdata = cmd.rec_hit ? size_rd + CW'(1) : CW'(1);
  assign tag_wdata  = cmd.rec_hit ? idx[AW-1:0] : gc[AW-1:0];
  assign cur_waddr  = cmd.pfx_wr ? idx[AW-1:0] : grp_q;
  assign cur_wdata  = cmd.pfx_wr ? acc[AW-1:0] : cur_rd + AW'(1);

  sgbk_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.rec_new),
    .waddr (gc[AW-1:0]),
    .wdata (key_q),
    .raddr (idx[AW-1:0]),
    .rdata (key_rd)
  );

  sgbk_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS)) u_size_ram (
    .clk   (clk),
    .we    (cmd.rec_hit || cmd.rec_new),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_rd)
  );

  sgbk_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.rec_hit || cmd.rec_new),
    .waddr (ic[AW-1:0]),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rd)
  );

  sgbk_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_off_ram (
    .clk   (clk),
    .we    (cmd.pfx_wr),
    .waddr (idx[AW-1:0]),
    .wdata (acc[AW-1:0]),
    .raddr (emit_addr),
    .rdata (off_rd)
  );

  sgbk_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_cur_ram (
    .clk   (clk),
    .we    (cmd.pfx_wr || cmd.sct_wr),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (tag_rd),
    .rdata (cur_rd)
  );

  sgbk_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_perm_ram (
    .clk   (clk),
    .we    (cmd.sct_wr),
    .waddr (cur_rd),
    .wdata (idx[AW-1:0]),
    .raddr (idx[AW-1:0]),
    .rdata (perm_rd)
  );

  // Output register: hold the beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      item_index  <= IDX_W'(item_q);
      group_index <= IDX_W'(grp_q);
      group_start <= IDX_W'(off_rd);
      group_size  <= CNT_W'(size_rd);
      group_total <= CNT_W'(gc);
      overflow    <= ovf;
      last_out    <= sts.end_item;
    end
  end

  assign sts.full     = (ic >= CW'(MAX_ITEMS));
  assign sts.gc_zero  = (gc == '0);
  assign sts.last_q   = last_q;
  assign sts.match    = (key_rd == key_q);
  assign sts.end_grp  = ((idx + CW'(1)) == gc);
  assign sts.end_item = ((idx + CW'(1)) == ic);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

@@ design/stable_group_by_key.sv @@
// Record: an item is loaded, checked, then compared group by group to the hit (all on a miss);
// the compare walks the key memory through its single read port, a read then a compare per group.
// Close: after the last item, prefix sums run over the groups and a scatter runs over the items,
// then results leave one at a time (perm, tag, group reads, then a load that waits out stalls).
// Reset: rst is synchronous, active high; counters, overflow flag and output valid clear,
// the memories keep their contents and need no clearing pass.
module stable_group_by_key import sgbk_pkg::*; #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] query_key,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   item_index,
  output logic [IDX_W-1:0]   group_index,
  output logic [IDX_W-1:0]   group_start,
  output logic [CNT_W-1:0]   group_size,
  output logic [CNT_W-1:0]   group_total,
  output logic               overflow,
  output logic               last_out
);

  cmd_t cmd;
  sts_t sts;

  sgbk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sgbk_dp #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .query_key   (query_key),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .item_index  (item_index),
    .group_index (group_index),
    .group_start (group_start),
    .group_size  (group_size),
    .group_total (group_total),
    .overflow    (overflow),
    .last_out    (last_out)
  );

endmodule

@@ design/sgbk_checker.sv @@
`include "assert_macros.svh"

module sgbk_checker import sgbk_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] item_index,
  input logic [IDX_W-1:0] group_index,
  input logic [CNT_W-1:0] group_size,
  input logic [CNT_W-1:0] group_total,
  input logic             last_out
);

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_hold_beat, out_valid && out_stall |=> out_valid && $stable(item_index), "stalled beat changed")
  `ASSERT_CLK(a_size_nonzero, out_valid |-> group_size != '0 && group_total != '0, "empty group emitted")
  `ASSERT_CLK(a_group_range, out_valid |-> CNT_W'(group_index) < group_total, "group index past group count")
  `ASSERT_CLK(a_no_intake, out_valid && !last_out |-> in_stall, "input taken while list still emitting")

endmodule

bind stable_group_by_key sgbk_checker u_sgbk_checker (.*);

@@ sim/stable_group_by_key_tb.sv @@
module stable_group_by_key_tb;
  import sgbk_pkg::*;

  localparam int CAP         = 64;
  localparam int TOTAL_ITEMS = 500;
  localparam int HOLD_OFF    = 800;
  localparam int WATCHDOG    = 4000;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic [IDX_W-1:0] item;
    logic [IDX_W-1:0] grp;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] size;
    logic [CNT_W-1:0] total;
    logic             ovf;
    logic             fin;
  } slot_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] query_key;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic [IDX_W-1:0]   item_index;
  logic [IDX_W-1:0]   group_index;
  logic [IDX_W-1:0]   group_start;
  logic [CNT_W-1:0]   group_size;
  logic [CNT_W-1:0]   group_total;
  logic               overflow;
  logic               last_out;

  // grouping state of the list being collected
  logic [31:0] seen_key [CAP];
  int unsigned seen_size [CAP];
  int unsigned item_grp [CAP];
  int unsigned n_items;
  int unsigned n_groups;
  bit          dropped;
  slot_t       perm_q [$];

  int  errors;
  int  items_sent;
  bit  idle_on;
  bit  hold_off_req;
  int  quiet;

  stable_group_by_key DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .query_key   (query_key),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_index  (item_index),
    .group_index (group_index),
    .group_start (group_start),
    .group_size  (group_size),
    .group_total (group_total),
    .overflow    (overflow),
    .last_out    (last_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Group one accepted key; on the closing beat queue the stable permutation.
  function automatic void group_key(logic [31:0] key, bit fin);
    int unsigned g;
    int unsigned start;
    int unsigned slot;
    slot_t       s;
    if (n_items >= CAP) begin
      dropped = 1'b1;
    end else begin
      g = 0;
      while (g < n_groups && seen_key[g] != key) g++;
      if (g == n_groups) begin
        seen_key[g]  = key;
        seen_size[g] = 0;
        n_groups++;
      end
      seen_size[g]++;
      item_grp[n_items] = g;
      n_items++;
    end
    if (fin) begin
      start = 0;
      slot  = 0;
      for (int unsigned gi = 0; gi < n_groups; gi++) begin
        for (int unsigned i = 0; i < n_items; i++) begin
          if (item_grp[i] == gi) begin
            slot++;
            s.item  = IDX_W'(i);
            s.grp   = IDX_W'(gi);
            s.start = IDX_W'(start);
            s.size  = CNT_W'(seen_size[gi]);
            s.total = CNT_W'(n_groups);
            s.ovf   = dropped;
            s.fin   = (slot == n_items);
            perm_q.push_back(s);
          end
        end
        start += seen_size[gi];
      end
      n_items  = 0;
      n_groups = 0;
      dropped  = 1'b0;
    end
  endfunction

  // Leave valid high between back-to-back beats; lower it only for a gap.
  task automatic send_item(logic [31:0] key, bit fin);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    query_key <= key;
    last      <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    group_key(key, fin);
    items_sent++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    slot_t want;
    if (!rst && out_valid && !out_stall) begin
      if (perm_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual item_index %0d",
                 $time, item_index);
      end else begin
        want = perm_q.pop_front();
        check_field("item_index", 32'(want.item), 32'(item_index));
        check_field("group_index", 32'(want.grp), 32'(group_index));
        check_field("group_start", 32'(want.start), 32'(group_start));
        check_field("group_size", 32'(want.size), 32'(group_size));
        check_field("group_total", 32'(want.total), 32'(group_total));
        check_field("overflow", 32'(want.ovf), 32'(overflow));
        check_field("last_out", 32'(want.fin), 32'(last_out));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int  stall_left;
    bit  nxt;
    out_stall <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        stall_left = 0;
        out_stall <= 1'b0;
      end else begin
        if (stall_left != 0) begin
          stall_left--;
          nxt = 1'b1;
        end else begin
          stall_left = pick_gap();
          nxt = (stall_left != 0);
          if (nxt) stall_left--;
        end
        out_stall <= nxt;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_single_item_lists();
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_same_key();
    for (int i = 0; i < 4; i++) send_item(32'h5A5A_A5A5, i == 3);
  endtask

  task automatic test_interleaved_keys();
    logic [31:0] keys [9];
    // keys that differ in one bit must land in different groups
    keys = '{32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
             32'h0000_0000, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF};
    for (int i = 0; i < 9; i++) send_item(keys[i], i == 8);
  endtask

  task automatic test_distinct_full();
    for (int i = 0; i < CAP; i++) send_item(i * 32'h9E37_79B9, i == CAP - 1);
  endtask

  task automatic test_one_group_full();
    for (int i = 0; i < CAP; i++) send_item(32'hFFFF_FFFE, i == CAP - 1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < CAP; i++) send_item(32'h0001_0000 * $urandom_range(0, 4), 1'b0);
    // dropped beats: a fresh key must not open a group; the last one still closes
    send_item(32'h1234_5678, 1'b0);
    send_item(32'h0001_0000, 1'b0);
    send_item(32'hDEAD_BEEF, 1'b1);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    for (int l = 0; l < 3; l++) begin
      for (int i = 0; i < 8; i++) send_item($urandom_range(0, 3), i == 7);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_lists();
    int          len;
    int          pool_n;
    int          r;
    logic [31:0] pool [16];
    logic [31:0] k;
    while (items_sent < TOTAL_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 10);
      else if (r < 90) len = $urandom_range(11, 40);
      else if (r < 96) len = $urandom_range(41, CAP);
      else len = $urandom_range(CAP + 1, CAP + 6);
      pool_n = $urandom_range(1, 16);
      for (int p = 0; p < 16; p++) pool[p] = rand_key();
      for (int i = 0; i < len; i++) begin
        k = ($urandom_range(0, 4) == 0) ? rand_key() : pool[$urandom_range(0, pool_n - 1)];
        send_item(k, i == len - 1);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    query_key <= '0;
    last      <= 1'b0;
    errors     = 0;
    items_sent = 0;
    idle_on    = 1'b1;
    hold_off_req = 1'b0;
    quiet      = 0;
    n_items    = 0;
    n_groups   = 0;
    dropped    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_item_lists();
    test_same_key();
    test_interleaved_keys();
    test_distinct_full();
    test_one_group_full();
    test_overflow();
    test_backpressure();
    test_random_lists();

    in_valid <= 1'b0;
    while (perm_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && perm_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sgbk_pkg.sv
design/sgbk_ram.sv
design/sgbk_ctrl.sv
design/sgbk_dp.sv
design/stable_group_by_key.sv
design/sgbk_checker.sv
sim/stable_group_by_key_tb.sv
